@@ design/ir_pwfd_pkg.sv @@
// Shared types, constants and the known-code table of the infrared frame decoder.
package ir_pwfd_pkg;

  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned TOL_W      = 12;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned INDEX_W    = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TABLE_SIZE = 27;

  localparam logic [INDEX_W-1:0] NO_MATCH = INDEX_W'(TABLE_SIZE);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE       = 3'd3;

  localparam logic [TOL_W-1:0]   TOLERANCE_RESET = 12'd200;
  localparam logic [PULSE_W-1:0] START_RESET     = 16'd4500;
  localparam logic [PULSE_W-1:0] ZERO_RESET      = 16'd500;
  localparam logic [PULSE_W-1:0] ONE_RESET       = 16'd1600;

  typedef enum logic [1:0] {
    STATUS_MATCH    = 2'd0,
    STATUS_NO_MATCH = 2'd1,
    STATUS_BAD_BIT  = 2'd2
  } status_t;

  typedef struct packed {
    logic [TOL_W-1:0]   tolerance_us;
    logic [PULSE_W-1:0] start_width_us;
    logic [PULSE_W-1:0] zero_width_us;
    logic [PULSE_W-1:0] one_width_us;
  } cfg_t;

  typedef struct packed {
    logic start_hit;
    logic zero_hit;
    logic one_hit;
  } class_t;

  localparam logic [CODE_W-1:0] CODE_TABLE [TABLE_SIZE] = '{
    32'h6996bb42, 32'h6d92bb42, 32'h2bd4bb42, 32'h748bbb42, 32'h37c8bb42,
    32'h35cabb42, 32'h36c9bb42, 32'h34cbbb42, 32'h00ffbb42, 32'h01febb42,
    32'h6798bb42, 32'h659abb42, 32'h639cbb42, 32'h649bbb42, 32'h609fbb42,
    32'h7e81bb42, 32'h7d82bb42, 32'h7c83bb42, 32'h7b84bb42, 32'h7a85bb42,
    32'h7986bb42, 32'h7887bb42, 32'h7788bb42, 32'h7689bb42, 32'h758abb42,
    32'h738cbb42, 32'h718ebb42
  };

endpackage

@@ design/ir_pwfd_classify.sv @@
// Pulse width classifier: tolerance window tests against the start, zero and one widths.
module ir_pwfd_classify
  import ir_pwfd_pkg::*;
(
  input  logic [PULSE_W-1:0] pulse_us,
  input  cfg_t               cfg,
  output class_t             hits
);

  logic [PULSE_W-1:0] dist_start;
  logic [PULSE_W-1:0] dist_zero;
  logic [PULSE_W-1:0] dist_one;
  logic [PULSE_W-1:0] tol_ext;

  function automatic logic [PULSE_W-1:0] distance(input logic [PULSE_W-1:0] a,
                                                  input logic [PULSE_W-1:0] b);
    distance = (a > b) ? (a - b) : (b - a);
  endfunction

  assign tol_ext    = PULSE_W'(cfg.tolerance_us);
  assign dist_start = distance(pulse_us, cfg.start_width_us);
  assign dist_zero  = distance(pulse_us, cfg.zero_width_us);
  assign dist_one   = distance(pulse_us, cfg.one_width_us);

  // The start window includes its bounds; the bit windows do not.
  assign hits.start_hit = (dist_start <= tol_ext);
  assign hits.zero_hit  = (dist_zero < tol_ext);
  assign hits.one_hit   = (dist_one < tol_ext);

endmodule

@@ design/ir_pwfd_lookup.sv @@
// Known-code search: the lowest table entry equal to the frame word wins.
module ir_pwfd_lookup
  import ir_pwfd_pkg::*;
#(
  parameter int unsigned NUM_CODES = 27
) (
  input  logic [CODE_W-1:0]  code_word,
  output logic               found,
  output logic [INDEX_W-1:0] index
);

  localparam int unsigned LIMIT = (NUM_CODES < TABLE_SIZE) ? NUM_CODES : TABLE_SIZE;

  always_comb begin
    found = 1'b0;
    index = NO_MATCH;
    // Walk downwards so that the lowest matching entry is the one kept.
    for (int i = LIMIT - 1; i >= 0; i--) begin
      if (CODE_TABLE[i] == code_word) begin
        found = 1'b1;
        index = INDEX_W'(i);
      end
    end
  end

endmodule

@@ design/ir_pulse_width_frame_decoder.sv @@
// Top level of the infrared pulse width frame decoder.
//
// Input channel: one measured pulse width (pulse_us) per transaction, taken when
// in_valid is high and in_stall is low. While hunting, a pulse within tolerance
// of the start width (bounds inclusive) opens a frame; FRAME_BITS bit pulses
// follow, least significant bit first.
// Output channel: one transaction per finished frame (status, code, button_index),
// taken when out_valid is high and out_stall is low. A frame that completes is
// looked up in the known-code table; a bit pulse outside both bit windows ends
// the frame early with the invalid-width status.
// A result moves into the result register when the pulse that ends the frame
// advances out of the input register.
// Throughput is one pulse per cycle while out_stall does not hold the result;
// the classify and table compare are combinational.
// While a result waits under out_stall, one more pulse is still taken into the
// input register; further pulses are stalled until the result leaves.
// The user must write configuration on cfg_write with cfg_index and cfg_data only
// while the decoder is idle; the block does not enforce this. Synchronous reset
// restores the default widths and tolerance, drops any pending transaction and hunts.
module ir_pulse_width_frame_decoder
  import ir_pwfd_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32,
  parameter int unsigned NUM_CODES  = 27
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PULSE_W-1:0]    pulse_us,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            status,
  output logic [CODE_W-1:0]     code,
  output logic [INDEX_W-1:0]    button_index
);

  localparam int unsigned COUNT_W = $clog2(FRAME_BITS + 1);
  localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(FRAME_BITS);

  cfg_t               cfg;
  logic               in_full;
  logic [PULSE_W-1:0] pulse;
  logic               collecting;
  logic [COUNT_W-1:0] bit_count;
  logic [CODE_W-1:0]  shift_word;

  logic               collecting_next;
  logic [COUNT_W-1:0] bit_count_next;
  logic [CODE_W-1:0]  shift_word_next;

  class_t             hits;
  logic               advance;
  logic               emit;
  logic               frame_done;
  logic               bit_value;
  logic [CODE_W-1:0]  word_with_bit;
  logic               found;
  logic [INDEX_W-1:0] match_index;
  status_t            status_next;
  logic [CODE_W-1:0]  code_next;
  logic [INDEX_W-1:0] index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance_us   <= TOLERANCE_RESET;
      cfg.start_width_us <= START_RESET;
      cfg.zero_width_us  <= ZERO_RESET;
      cfg.one_width_us   <= ONE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TOLERANCE: cfg.tolerance_us   <= cfg_data[TOL_W-1:0];
        REG_START:     cfg.start_width_us <= cfg_data;
        REG_ZERO:      cfg.zero_width_us  <= cfg_data;
        REG_ONE:       cfg.one_width_us   <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pulse moves on once the result register is free or being emptied.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pulse <= pulse_us;
    end
  end

  ir_pwfd_classify u_classify (
    .pulse_us (pulse),
    .cfg      (cfg),
    .hits     (hits)
  );

  assign bit_value     = !hits.zero_hit;
  assign word_with_bit = shift_word | (CODE_W'(bit_value) << bit_count);
  assign frame_done    = (bit_count + COUNT_W'(1)) == LAST_COUNT;

  ir_pwfd_lookup #(
    .NUM_CODES (NUM_CODES)
  ) u_lookup (
    .code_word (word_with_bit),
    .found     (found),
    .index     (match_index)
  );

  always_comb begin
    collecting_next = collecting;
    bit_count_next  = bit_count;
    shift_word_next = shift_word;
    emit            = 1'b0;
    status_next     = STATUS_NO_MATCH;
    code_next       = word_with_bit;
    index_next      = NO_MATCH;
    if (!collecting) begin
      if (hits.start_hit) begin
        collecting_next = 1'b1;
        bit_count_next  = '0;
        shift_word_next = '0;
      end
    end else if (!hits.zero_hit && !hits.one_hit) begin
      emit            = 1'b1;
      status_next     = STATUS_BAD_BIT;
      code_next       = shift_word;
      collecting_next = 1'b0;
      bit_count_next  = '0;
      shift_word_next = '0;
    end else if (frame_done) begin
      emit            = 1'b1;
      status_next     = found ? STATUS_MATCH : STATUS_NO_MATCH;
      index_next      = match_index;
      collecting_next = 1'b0;
      bit_count_next  = '0;
      shift_word_next = '0;
    end else begin
      bit_count_next  = bit_count + COUNT_W'(1);
      shift_word_next = word_with_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting <= 1'b0;
      bit_count  <= '0;
      shift_word <= '0;
    end else if (advance) begin
      collecting <= collecting_next;
      bit_count  <= bit_count_next;
      shift_word <= shift_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      status       <= status_next;
      code         <= code_next;
      button_index <= index_next;
    end
  end

endmodule

@@ design/ir_pwfd_checker.sv @@
// Port-level assertions for the infrared frame decoder, bound to its top level.
module ir_pwfd_checker
  import ir_pwfd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic [CODE_W-1:0]  code,
  input logic [INDEX_W-1:0] button_index
);

  // A stalled result transaction stays and holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(code)
                               && $stable(button_index))
    else $error("result changed while stalled");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STATUS_MATCH || status == STATUS_NO_MATCH
                  || status == STATUS_BAD_BIT)
    else $error("illegal status code");

  a_match_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_MATCH |-> button_index < NO_MATCH)
    else $error("matched frame without a table index");

  a_nomatch_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_NO_MATCH || status == STATUS_BAD_BIT)
    |-> button_index == NO_MATCH)
    else $error("unmatched or bad frame carries a table index");

endmodule

bind ir_pulse_width_frame_decoder ir_pwfd_checker u_ir_pwfd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .code         (code),
  .button_index (button_index)
);

@@ tb/ir_pulse_width_frame_decoder_tb.sv @@
// Self-checking testbench for the infrared pulse width frame decoder.
`timescale 1ns / 100ps

module ir_pulse_width_frame_decoder_tb;
  import ir_pwfd_pkg::*;

  localparam int unsigned FRAME_BITS  = 32;
  localparam int unsigned NUM_CODES   = 27;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned HOLD_OFF    = 300;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 90;

  typedef struct {
    status_t              status;
    logic [CODE_W-1:0]    code;
    logic [INDEX_W-1:0]   button;
  } frame_result_t;

  // Mirrors the decoder state and checks every result transaction in order.
  class ir_frame_checker;
    logic [TOL_W-1:0]   tol;
    logic [PULSE_W-1:0] start_w;
    logic [PULSE_W-1:0] zero_w;
    logic [PULSE_W-1:0] one_w;
    bit                 collecting;
    logic [5:0]         bit_count;
    logic [CODE_W-1:0]  shift_word;
    frame_result_t      pending_frames[$];
    int unsigned        pulses, predicted, checked, mismatches;
    int unsigned        n_match, n_nomatch, n_badbit;

    function new();
      tol        = TOLERANCE_RESET;
      start_w    = START_RESET;
      zero_w     = ZERO_RESET;
      one_w      = ONE_RESET;
      collecting = 1'b0;
      bit_count  = '0;
      shift_word = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_TOLERANCE: tol = val[TOL_W-1:0];
        REG_START:     start_w = val;
        REG_ZERO:      zero_w = val;
        REG_ONE:       one_w = val;
        default: ;
      endcase
    endfunction

    static function int unsigned span(int unsigned a, int unsigned b);
      return a > b ? a - b : b - a;
    endfunction

    function void push_frame(status_t st, logic [INDEX_W-1:0] btn);
      frame_result_t r;
      r.status = st;
      r.code   = shift_word;
      r.button = btn;
      pending_frames.push_back(r);
      predicted++;
      collecting = 1'b0;
      bit_count  = '0;
      shift_word = '0;
    endfunction

    function void note_pulse(logic [PULSE_W-1:0] w);
      bit                 b;
      int unsigned        limit;
      logic [INDEX_W-1:0] btn;
      pulses++;
      if (!collecting) begin
        if (span(w, start_w) <= tol) begin
          collecting = 1'b1;
          bit_count  = '0;
          shift_word = '0;
        end
        return;
      end
      // The zero window is tested first, so it wins where the windows overlap.
      if (span(w, zero_w) < tol) begin
        b = 1'b0;
      end else if (span(w, one_w) < tol) begin
        b = 1'b1;
      end else begin
        push_frame(STATUS_BAD_BIT, NO_MATCH);
        return;
      end
      if (bit_count < 32) shift_word = shift_word | (CODE_W'(b) << bit_count);
      bit_count = bit_count + 6'd1;
      if (bit_count < FRAME_BITS) return;
      limit = NUM_CODES < TABLE_SIZE ? NUM_CODES : TABLE_SIZE;
      btn = NO_MATCH;
      for (int unsigned i = 0; i < limit; i++) begin
        if (CODE_TABLE[i] == shift_word) begin
          btn = INDEX_W'(i);
          break;
        end
      end
      push_frame(btn == NO_MATCH ? STATUS_NO_MATCH : STATUS_MATCH, btn);
    endfunction

    function void check_frame(logic [1:0] st, logic [CODE_W-1:0] cd,
                              logic [INDEX_W-1:0] bi);
      frame_result_t e;
      if (pending_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d code %h button %0d", st, cd, bi);
        return;
      end
      e = pending_frames.pop_front();
      checked++;
      case (e.status)
        STATUS_MATCH:    n_match++;
        STATUS_NO_MATCH: n_nomatch++;
        default:         n_badbit++;
      endcase
      if (st !== e.status || cd !== e.code || bi !== e.button) begin
        mismatches++;
        if (mismatches <= 10)
          $display("frame %0d mismatch: status %0d/%0d code %h/%h button %0d/%0d",
                   checked, e.status, st, e.code, cd, e.button, bi);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PULSE_W-1:0]    pulse_us = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            status;
  logic [CODE_W-1:0]     code;
  logic [INDEX_W-1:0]    button_index;

  ir_frame_checker chk = new();
  int unsigned     cycles = 0;
  int unsigned     frame_items = 0;
  int unsigned     settings_used = 1;
  bit              sender_quiet = 1'b0;
  bit              hold_req = 1'b0;
  bit              stall_mode = 1'b0;
  int unsigned     run_left = 0;

  ir_pulse_width_frame_decoder #(
    .FRAME_BITS(FRAME_BITS),
    .NUM_CODES (NUM_CODES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pulse_us    (pulse_us),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .code        (code),
    .button_index(button_index)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, chk.pending_frames.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: checks every transaction and varies out_stall in runs.
  initial begin
    int unsigned r;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) chk.check_frame(status, code, button_index);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_mode = 1'b1;
        run_left   = HOLD_OFF;
      end else if (run_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          stall_mode = 1'b0;
          run_left   = $urandom_range(1, 24);
        end else if (r < 93) begin
          stall_mode = 1'b1;
          run_left   = $urandom_range(1, 3);
        end else begin
          stall_mode = 1'b1;
          run_left   = $urandom_range(15, 60);
        end
      end else begin
        run_left--;
      end
      out_stall <= stall_mode;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (sender_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_near(int unsigned nom, int unsigned dev);
    int unsigned lo, hi, pick;
    lo   = nom > dev ? nom - dev : 0;
    hi   = nom + dev > 65535 ? 65535 : nom + dev;
    pick = $urandom_range(0, 9);
    if (pick == 0) return PULSE_W'(lo);
    if (pick == 1) return PULSE_W'(hi);
    return PULSE_W'($urandom_range(hi, lo));
  endfunction

  function automatic logic [PULSE_W-1:0] bit_pulse(bit b);
    int unsigned dev;
    dev = chk.tol == 0 ? 0 : chk.tol - 1;
    return pulse_near(b ? chk.one_w : chk.zero_w, dev);
  endfunction

  task automatic send_pulse(input logic [PULSE_W-1:0] p);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pulse_us <= p;
    do @(posedge clk); while (in_stall);
    chk.note_pulse(p);
  endtask

  task automatic send_frame(input logic [CODE_W-1:0] word);
    send_pulse(pulse_near(chk.start_w, chk.tol));
    for (int unsigned i = 0; i < FRAME_BITS; i++) send_pulse(bit_pulse(word[i]));
    frame_items += FRAME_BITS + 1;
  endtask

  // A frame cut short by a width that is most likely outside both bit windows.
  task automatic send_broken(input int unsigned nbits);
    logic [PULSE_W-1:0] bad;
    int unsigned        r;
    send_pulse(pulse_near(chk.start_w, chk.tol));
    for (int unsigned i = 0; i < nbits; i++) send_pulse(bit_pulse($urandom_range(0, 1)));
    r = $urandom_range(0, 3);
    case (r)
      0:       bad = PULSE_W'($urandom);
      1:       bad = pulse_near(chk.start_w, chk.tol);
      2:       bad = pulse_near(int'(chk.zero_w) + int'(chk.tol), 0);
      default: bad = '0;
    endcase
    send_pulse(bad);
    frame_items += nbits + 2;
  endtask

  task automatic random_frame();
    int unsigned       r;
    logic [CODE_W-1:0] word;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      send_frame(CODE_TABLE[$urandom_range(0, TABLE_SIZE - 1)]);
    end else if (r < 45) begin
      word = CODE_TABLE[$urandom_range(0, TABLE_SIZE - 1)];
      word[$urandom_range(0, CODE_W - 1)] ^= 1'b1;
      send_frame(word);
    end else if (r < 65) begin
      send_frame($urandom);
    end else if (r < 88) begin
      send_broken($urandom_range(0, FRAME_BITS - 1));
    end else begin
      repeat ($urandom_range(1, 6)) send_pulse(PULSE_W'($urandom));
    end
  endtask

  // Feeds zero-width bits until the decoder is back to hunting.
  task automatic close_frame();
    while (chk.collecting) send_pulse(chk.zero_w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chk.pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_regs(input int unsigned t, input int unsigned s,
                              input int unsigned z, input int unsigned o);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    idx = '{REG_TOLERANCE, REG_START, REG_ZERO, REG_ONE};
    val = '{CFG_DATA_W'(t), CFG_DATA_W'(s), CFG_DATA_W'(z), CFG_DATA_W'(o)};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      chk.set_reg(idx[i], val[i]);
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int unsigned first_item, first_result;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset widths: window edges, timeout and saturated pulses, start inside a frame.
    send_pulse(16'd4299);
    send_pulse(16'd4701);
    send_pulse(16'd0);
    send_pulse(16'd65535);
    send_pulse(16'd4300);
    send_pulse(16'd301);
    send_pulse(16'd1401);
    send_pulse(16'd300);
    send_pulse(16'd4700);
    send_pulse(16'd1799);
    send_pulse(16'd4500);
    send_pulse(16'd4500);
    send_pulse(16'd0);
    send_pulse(16'd4500);
    send_pulse(16'd65535);
    wait_drained();

    // Long receiver hold-off against a run of short failing frames.
    hold_req     = 1'b1;
    sender_quiet = 1'b1;
    repeat (10) begin
      send_pulse(16'd4500);
      send_pulse(16'd0);
    end
    sender_quiet = 1'b0;
    wait_drained();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      close_frame();
      wait_drained();
      case (ph)
        0: ;
        1: program_regs(4095, 65535, 0, 65535);
        2: program_regs(0, 0, 500, 1600);
        3: program_regs(1, 4500, 560, 1690);
        4: program_regs(800, 9000, 1000, 1500);
        5: program_regs($urandom_range(1, 600), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
        6: program_regs($urandom_range(1, 4095), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), $urandom_range(0, 65535));
        default: program_regs(200, 4500, 500, 1600);
      endcase
      first_item   = frame_items;
      first_result = chk.predicted;
      while (frame_items - first_item < PHASE_ITEMS || chk.predicted - first_result < 3) begin
        sender_quiet = ($urandom_range(0, 4) == 0);
        random_frame();
      end
    end
    sender_quiet = 1'b0;
    close_frame();
    wait_drained();

    $display("Covered %0d pulses under %0d register settings, %0d frames checked",
             chk.pulses, settings_used, chk.checked);
    $display("(%0d matched, %0d unmatched, %0d invalid width), %0d mismatches",
             chk.n_match, chk.n_nomatch, chk.n_badbit, chk.mismatches);
    if (chk.mismatches == 0 && chk.pending_frames.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
